FILE: design/iec104st_pkg.sv
// ----------------------------------------------------------------------------
// iec104st_pkg
// shared types, field widths and codes of the sequence tracker
// ----------------------------------------------------------------------------
package iec104st_pkg;

  localparam int SEQ_W = 15;
  localparam int OBS_W = 14;
  localparam int CNT_W = 32;
  localparam int UF_W  = 6;

  localparam logic [OBS_W-1:0] OBS_MAX = {OBS_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic       CMD_FRAME  = 1'b0;
  localparam logic       CMD_REPORT = 1'b1;

  localparam logic [1:0] KIND_U = 2'd0;
  localparam logic [1:0] KIND_I = 2'd1;
  localparam logic [1:0] KIND_S = 2'd2;

  localparam logic [2:0] UCODE_FIRST = 3'd1;
  localparam logic [2:0] UCODE_LAST  = 3'd6;

  localparam logic [1:0] RES_ACK     = 2'd0;
  localparam logic [1:0] RES_DIR     = 2'd1;
  localparam logic [1:0] RES_SUMMARY = 2'd2;

  // classified beat as it waits between front and back
  typedef struct packed {
    logic             report;
    logic [3:0]       dir;
    logic             iframe;
    logic             ack;
    logic [UF_W-1:0]  u_set;
    logic [SEQ_W-1:0] send_seq;
    logic [SEQ_W-1:0] recv_seq;
  } item_t;

  // one send table entry
  typedef struct packed {
    logic [SEQ_W-1:0] first_send;
    logic [SEQ_W-1:0] expected_send;
    logic [SEQ_W-1:0] last_send;
    logic [OBS_W-1:0] iframes;
  } send_rec_t;

  localparam int SEND_REC_W = $bits(send_rec_t);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

FILE: design/iec104_sequence_tracker.sv
// ----------------------------------------------------------------------------
// iec104_sequence_tracker
// IEC 104 send and receive sequence monitor over a table of directions
// ----------------------------------------------------------------------------
// Takes parsed frames and report commands as input beats. A two-beat queue
// sits between the front end and the table engine, so new beats are taken
// while the engine works or a result waits. A frame goes through a table
// read in the engine, then update and acknowledgement. A report first takes
// the beat off the queue, then skips each inactive direction, reads, checks
// and emits each active direction, and ends with the summary, a walk set by
// the single read port of each direction table. Valid bits cover the tables,
// so there is no clearing pass after reset. Directions 2k and 2k+1 are peers;
// counters saturate.
module iec104_sequence_tracker #(
  parameter int NUM_DIRECTIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [3:0]  in_direction,
  input  logic [1:0]  in_frame_kind,
  input  logic [2:0]  in_u_code,
  input  logic [14:0] in_send_seq,
  input  logic [14:0] in_recv_seq,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_frame_count,
  output logic [31:0] out_gap_count,
  output logic [31:0] out_duplicate_count,
  output logic [5:0]  out_u_seen_flags,
  output logic [3:0]  out_dir_index,
  output logic [14:0] out_latest_send,
  output logic [14:0] out_highest_ack,
  output logic        out_ack_seen,
  output logic [13:0] out_outstanding,
  output logic        out_last
);
  import iec104st_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  iec104st_front #(.NUM_DIRECTIONS(NUM_DIRECTIONS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_direction  (in_direction),
    .in_frame_kind (in_frame_kind),
    .in_u_code     (in_u_code),
    .in_send_seq   (in_send_seq),
    .in_recv_seq   (in_recv_seq),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  iec104st_back #(.NUM_DIRECTIONS(NUM_DIRECTIONS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_frame_count     (out_frame_count),
    .out_gap_count       (out_gap_count),
    .out_duplicate_count (out_duplicate_count),
    .out_u_seen_flags    (out_u_seen_flags),
    .out_dir_index       (out_dir_index),
    .out_latest_send     (out_latest_send),
    .out_highest_ack     (out_highest_ack),
    .out_ack_seen        (out_ack_seen),
    .out_outstanding     (out_outstanding),
    .out_last            (out_last)
  );

endmodule

FILE: design/iec104st_ram.sv
// ----------------------------------------------------------------------------
// iec104st_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module iec104st_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/iec104st_front.sv
// ----------------------------------------------------------------------------
// iec104st_front
// accepts input beats, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module iec104st_front #(
  parameter int NUM_DIRECTIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_command,
  input  logic [3:0]           in_direction,
  input  logic [1:0]           in_frame_kind,
  input  logic [2:0]           in_u_code,
  input  logic [14:0]          in_send_seq,
  input  logic [14:0]          in_recv_seq,
  output logic                 q_valid,
  output iec104st_pkg::item_t  q_item,
  input  logic                 q_pop
);
  import iec104st_pkg::*;

  localparam int AW = $clog2(NUM_DIRECTIONS);
  localparam int DW = (AW > 4) ? AW : 4;

  item_t       entry_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  item_t       cls;
  logic [DW-1:0] dir_ext;
  logic        dir_ok, peer_ok, is_frame;

  // classification
  always_comb begin
    dir_ext  = DW'(in_direction);
    dir_ok   = {1'b0, dir_ext} < (DW+1)'(NUM_DIRECTIONS);
    peer_ok  = {1'b0, dir_ext ^ DW'(1)} < (DW+1)'(NUM_DIRECTIONS);
    is_frame = (in_command == CMD_FRAME);
    cls          = '0;
    cls.report   = (in_command == CMD_REPORT);
    cls.dir      = in_direction;
    cls.iframe   = is_frame && (in_frame_kind == KIND_I) && dir_ok;
    cls.ack      = is_frame && ((in_frame_kind == KIND_I) || (in_frame_kind == KIND_S))
                   && dir_ok && peer_ok;
    cls.send_seq = in_send_seq;
    cls.recv_seq = in_recv_seq;
    if (is_frame && (in_frame_kind == KIND_U) && (in_u_code >= UCODE_FIRST)
        && (in_u_code <= UCODE_LAST)) begin
      cls.u_set = UF_W'(1) << (in_u_code - UCODE_FIRST);
    end
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = entry_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = ~wptr_r;
    end
    if (q_pop) begin
      rptr_nxt = ~rptr_r;
    end
    case ({push, q_pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= cls;
    end
  end

endmodule

FILE: design/iec104st_back.sv
// ----------------------------------------------------------------------------
// iec104st_back
// direction tables, global counters, report walk and result register
// ----------------------------------------------------------------------------
module iec104st_back #(
  parameter int NUM_DIRECTIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  iec104st_pkg::item_t  q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_result_kind,
  output logic [31:0]          out_frame_count,
  output logic [31:0]          out_gap_count,
  output logic [31:0]          out_duplicate_count,
  output logic [5:0]           out_u_seen_flags,
  output logic [3:0]           out_dir_index,
  output logic [14:0]          out_latest_send,
  output logic [14:0]          out_highest_ack,
  output logic                 out_ack_seen,
  output logic [13:0]          out_outstanding,
  output logic                 out_last
);
  import iec104st_pkg::*;

  localparam int AW = $clog2(NUM_DIRECTIONS);
  localparam int DW = (AW > 4) ? AW : 4;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FUPD  = 6'b000010,
    S_RRD   = 6'b000100,
    S_RCHK  = 6'b001000,
    S_REMIT = 6'b010000,
    S_SUM   = 6'b100000
  } state_t;

  state_t                  state_r, state_nxt;
  item_t                   cur_r, cur_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic [OBS_W-1:0]        maxo_r, maxo_nxt;
  logic [OBS_W-1:0]        est_r, est_nxt;
  logic [CNT_W-1:0]        frames_r, frames_nxt;
  logic [CNT_W-1:0]        gaps_r, gaps_nxt;
  logic [CNT_W-1:0]        dups_r, dups_nxt;
  logic [UF_W-1:0]         uflags_r, uflags_nxt;
  logic [NUM_DIRECTIONS-1:0] send_vld_r, send_vld_nxt;
  logic [NUM_DIRECTIONS-1:0] ack_vld_r, ack_vld_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // result payload
  logic [1:0]              res_kind_r;
  logic [CNT_W-1:0]        res_frames_r, res_gaps_r, res_dups_r;
  logic [UF_W-1:0]         res_uflags_r;
  logic [3:0]              res_dir_r;
  logic [SEQ_W-1:0]        res_latest_r, res_ack_r;
  logic                    res_ack_seen_r;
  logic [OBS_W-1:0]        res_outst_r;
  logic                    res_last_r;

  logic                    load;
  logic [1:0]              ld_kind;
  logic [3:0]              ld_dir;
  logic [SEQ_W-1:0]        ld_latest, ld_ack;
  logic                    ld_ack_seen;
  logic [OBS_W-1:0]        ld_outst;
  logic                    ld_last;

  // table ports
  logic                    send_we, send_re, ack_we, ack_re;
  logic [AW-1:0]           send_waddr, send_raddr, ack_waddr, ack_raddr;
  logic [SEND_REC_W-1:0]   send_wdata, send_rdata;
  logic [SEQ_W-1:0]        ack_wdata, ack_rdata;

  logic [DW-1:0]           q_dir_ext, c_dir_ext, idx_ext;
  logic [AW-1:0]           q_saddr, q_paddr, c_saddr, c_paddr;
  logic                    out_free, idx_last;
  send_rec_t               rec, new_rec;
  logic                    rec_vld, ack_vld;
  logic [SEQ_W-1:0]        ack_cur, ahead, ack_dist, base, raw;
  logic                    gap_hit, dup_hit, ack_take;
  logic [OBS_W-1:0]        est;

  iec104st_ram #(.WIDTH(SEND_REC_W), .DEPTH(NUM_DIRECTIONS)) u_send_ram (
    .clk   (clk),
    .we    (send_we),
    .waddr (send_waddr),
    .wdata (send_wdata),
    .re    (send_re),
    .raddr (send_raddr),
    .rdata (send_rdata)
  );

  iec104st_ram #(.WIDTH(SEQ_W), .DEPTH(NUM_DIRECTIONS)) u_ack_ram (
    .clk   (clk),
    .we    (ack_we),
    .waddr (ack_waddr),
    .wdata (ack_wdata),
    .re    (ack_re),
    .raddr (ack_raddr),
    .rdata (ack_rdata)
  );

  always_comb begin
    q_dir_ext = DW'(q_item.dir);
    c_dir_ext = DW'(cur_r.dir);
    idx_ext   = DW'(idx_r);
    q_saddr   = q_dir_ext[AW-1:0];
    q_paddr   = q_saddr ^ AW'(1);
    c_saddr   = c_dir_ext[AW-1:0];
    c_paddr   = c_saddr ^ AW'(1);
    out_free  = !out_valid_r || !out_stall;
    idx_last  = (idx_r == AW'(NUM_DIRECTIONS - 1));
  end

  // entry view: frames look at the current beat, reports at the walk index
  always_comb begin
    if (state_r == S_FUPD) begin
      rec_vld = send_vld_r[c_saddr];
      ack_vld = ack_vld_r[c_paddr];
    end else begin
      rec_vld = send_vld_r[idx_r];
      ack_vld = ack_vld_r[idx_r];
    end
    rec     = rec_vld ? send_rec_t'(send_rdata) : '0;
    ack_cur = ack_vld ? ack_rdata : '0;

    // frame update
    ahead    = cur_r.send_seq - rec.expected_send;
    ack_dist = cur_r.recv_seq - ack_cur;
    gap_hit  = 1'b0;
    dup_hit  = 1'b0;
    new_rec  = rec;
    if (!rec_vld) begin
      new_rec.first_send    = cur_r.send_seq;
      new_rec.expected_send = cur_r.send_seq + SEQ_W'(1);
    end else if (cur_r.send_seq == rec.expected_send - SEQ_W'(1)) begin
      dup_hit = 1'b1;
    end else begin
      if (ahead != '0) begin
        gap_hit = !ahead[SEQ_W-1];
        dup_hit = ahead[SEQ_W-1];
      end
      new_rec.expected_send = cur_r.send_seq + SEQ_W'(1);
    end
    new_rec.last_send = cur_r.send_seq;
    new_rec.iframes   = (rec.iframes == OBS_MAX) ? rec.iframes : rec.iframes + OBS_W'(1);
    ack_take = cur_r.ack && (!ack_vld || !ack_dist[SEQ_W-1]);

    // outstanding estimate
    base = ack_vld ? ack_cur : rec.first_send;
    raw  = rec.last_send + SEQ_W'(1) - base;
    if (raw[SEQ_W-1]) begin
      est = '0;
    end else if (raw[OBS_W-1:0] < rec.iframes) begin
      est = raw[OBS_W-1:0];
    end else begin
      est = rec.iframes;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    maxo_nxt      = maxo_r;
    est_nxt       = est_r;
    frames_nxt    = frames_r;
    gaps_nxt      = gaps_r;
    dups_nxt      = dups_r;
    uflags_nxt    = uflags_r;
    send_vld_nxt  = send_vld_r;
    ack_vld_nxt   = ack_vld_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    send_we       = 1'b0;
    ack_we        = 1'b0;
    send_waddr    = c_saddr;
    ack_waddr     = c_paddr;
    send_wdata    = new_rec;
    ack_wdata     = cur_r.recv_seq;
    send_re       = 1'b0;
    ack_re        = 1'b0;
    send_raddr    = idx_r;
    ack_raddr     = idx_r;
    load          = 1'b0;
    ld_kind       = RES_ACK;
    ld_dir        = '0;
    ld_latest     = '0;
    ld_ack        = '0;
    ld_ack_seen   = 1'b0;
    ld_outst      = '0;
    ld_last       = 1'b0;

    case (state_r)
      S_IDLE: begin
        send_raddr = q_saddr;
        ack_raddr  = q_paddr;
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_item;
          if (q_item.report) begin
            idx_nxt   = '0;
            maxo_nxt  = '0;
            state_nxt = S_RRD;
          end else begin
            send_re   = 1'b1;
            ack_re    = 1'b1;
            state_nxt = S_FUPD;
          end
        end
      end
      S_FUPD: begin
        if (out_free) begin
          frames_nxt = sat_inc(frames_r);
          uflags_nxt = uflags_r | cur_r.u_set;
          if (cur_r.iframe) begin
            send_we              = 1'b1;
            send_vld_nxt[c_saddr] = 1'b1;
            if (gap_hit) begin
              gaps_nxt = sat_inc(gaps_r);
            end
            if (dup_hit) begin
              dups_nxt = sat_inc(dups_r);
            end
          end
          if (ack_take) begin
            ack_we               = 1'b1;
            ack_vld_nxt[c_paddr] = 1'b1;
          end
          load          = 1'b1;
          ld_kind       = RES_ACK;
          ld_last       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RRD: begin
        if (send_vld_r[idx_r]) begin
          send_re   = 1'b1;
          ack_re    = 1'b1;
          state_nxt = S_RCHK;
        end else if (idx_last) begin
          state_nxt = S_SUM;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_RCHK: begin
        est_nxt   = est;
        state_nxt = S_REMIT;
      end
      S_REMIT: begin
        if (out_free) begin
          load          = 1'b1;
          ld_kind       = RES_DIR;
          ld_dir        = idx_ext[3:0];
          ld_latest     = rec.last_send;
          ld_ack        = ack_cur;
          ld_ack_seen   = ack_vld;
          ld_outst      = est_r;
          out_valid_nxt = 1'b1;
          if (est_r > maxo_r) begin
            maxo_nxt = est_r;
          end
          if (idx_last) begin
            state_nxt = S_SUM;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_RRD;
          end
        end
      end
      S_SUM: begin
        if (out_free) begin
          load          = 1'b1;
          ld_kind       = RES_SUMMARY;
          ld_outst      = maxo_r;
          ld_last       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      maxo_r      <= '0;
      frames_r    <= '0;
      gaps_r      <= '0;
      dups_r      <= '0;
      uflags_r    <= '0;
      send_vld_r  <= '0;
      ack_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      maxo_r      <= maxo_nxt;
      frames_r    <= frames_nxt;
      gaps_r      <= gaps_nxt;
      dups_r      <= dups_nxt;
      uflags_r    <= uflags_nxt;
      send_vld_r  <= send_vld_nxt;
      ack_vld_r   <= ack_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    est_r <= est_nxt;
    if (load) begin
      res_kind_r     <= ld_kind;
      res_frames_r   <= frames_nxt;
      res_gaps_r     <= gaps_nxt;
      res_dups_r     <= dups_nxt;
      res_uflags_r   <= uflags_nxt;
      res_dir_r      <= ld_dir;
      res_latest_r   <= ld_latest;
      res_ack_r      <= ld_ack;
      res_ack_seen_r <= ld_ack_seen;
      res_outst_r    <= ld_outst;
      res_last_r     <= ld_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = res_kind_r;
  assign out_frame_count     = res_frames_r;
  assign out_gap_count       = res_gaps_r;
  assign out_duplicate_count = res_dups_r;
  assign out_u_seen_flags    = res_uflags_r;
  assign out_dir_index       = res_dir_r;
  assign out_latest_send     = res_latest_r;
  assign out_highest_ack     = res_ack_r;
  assign out_ack_seen        = res_ack_seen_r;
  assign out_outstanding     = res_outst_r;
  assign out_last            = res_last_r;

endmodule

FILE: test/tb_iec104_sequence_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iec104_sequence_tracker
// self-checking bench for the IEC 104 sequence tracker
// ----------------------------------------------------------------------------
// A queue of frame and report beats feeds a clocked driver. Each accepted beat
// goes through a local model of the direction table, and the results it should
// cause are queued. A clocked monitor checks every result beat field by field
// against the oldest queued result. The directed beats cover the U codes,
// the unused kind, N(S) wrap, gaps, duplicates, rollbacks and N(R) updates.
// Random sessions follow. Both sides idle at random. There is one long output
// hold-off, one quiet stretch, and two pauses of the sender until all results
// are in.
// ----------------------------------------------------------------------------
module tb_iec104_sequence_tracker;
  import iec104st_pkg::*;

  localparam int NDIR     = 16;
  localparam int LIMIT    = 300000;
  localparam int HOLD_AT  = 60;
  localparam int HOLD_LEN = 400;
  localparam int TAIL     = 60;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] UCODE_OTHER = 3'd0;
  localparam logic [2:0] UCODE_SPARE = 3'd7;

  typedef struct {
    logic        cmd;
    logic [3:0]  dir;
    logic [1:0]  kind;
    logic [2:0]  uc;
    logic [14:0] ns;
    logic [14:0] nr;
    bit          drain;
  } frame_beat_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] frames;
    logic [31:0] gaps;
    logic [31:0] dups;
    logic [5:0]  uflags;
    logic [3:0]  dir;
    logic [14:0] latest;
    logic [14:0] ack;
    logic        ack_seen;
    logic [13:0] outstanding;
    logic        last;
  } track_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_command = 1'b0;
  logic [3:0]  in_direction = '0;
  logic [1:0]  in_frame_kind = '0;
  logic [2:0]  in_u_code = '0;
  logic [14:0] in_send_seq = '0;
  logic [14:0] in_recv_seq = '0;
  logic        out_stall = 1'b0;
  wire         in_stall;
  wire         out_valid;
  wire [1:0]   out_result_kind;
  wire [31:0]  out_frame_count;
  wire [31:0]  out_gap_count;
  wire [31:0]  out_duplicate_count;
  wire [5:0]   out_u_seen_flags;
  wire [3:0]   out_dir_index;
  wire [14:0]  out_latest_send;
  wire [14:0]  out_highest_ack;
  wire         out_ack_seen;
  wire [13:0]  out_outstanding;
  wire         out_last;

  iec104_sequence_tracker #(.NUM_DIRECTIONS(NDIR)) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_direction       (in_direction),
    .in_frame_kind      (in_frame_kind),
    .in_u_code          (in_u_code),
    .in_send_seq        (in_send_seq),
    .in_recv_seq        (in_recv_seq),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_frame_count    (out_frame_count),
    .out_gap_count      (out_gap_count),
    .out_duplicate_count(out_duplicate_count),
    .out_u_seen_flags   (out_u_seen_flags),
    .out_dir_index      (out_dir_index),
    .out_latest_send    (out_latest_send),
    .out_highest_ack    (out_highest_ack),
    .out_ack_seen       (out_ack_seen),
    .out_outstanding    (out_outstanding),
    .out_last           (out_last)
  );

  always #4 clk = ~clk;

  // model of the direction table
  logic        d_seen     [NDIR];
  logic [14:0] d_first    [NDIR];
  logic [14:0] d_expect   [NDIR];
  logic [14:0] d_last     [NDIR];
  logic [14:0] d_ack      [NDIR];
  logic        d_ack_seen [NDIR];
  logic [13:0] d_iframes  [NDIR];
  logic [31:0] n_frames = '0;
  logic [31:0] n_gaps = '0;
  logic [31:0] n_dups = '0;
  logic [5:0]  u_flags = '0;

  frame_beat_t beat_q[$];
  track_res_t  want_q[$];
  frame_beat_t cur;
  int          beats_in = 0;
  int          exp_cnt = 0;
  int          got_cnt = 0;
  int          reports = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  wire quiet = (beats_in >= 200) && (beats_in < 260);

  function automatic logic [31:0] sat_bump(input logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

  function automatic track_res_t base_result(input logic [1:0] kind);
    track_res_t r;
    r = '{default: '0};
    r.kind   = kind;
    r.frames = n_frames;
    r.gaps   = n_gaps;
    r.dups   = n_dups;
    r.uflags = u_flags;
    return r;
  endfunction

  task automatic track_beat(input frame_beat_t b, output int n);
    track_res_t  r;
    logic [3:0]  d;
    logic [3:0]  p;
    logic [14:0] prev;
    logic [14:0] ahead;
    logic [14:0] fwd;
    logic [14:0] base;
    logic [14:0] raw;
    logic [13:0] est;
    logic [13:0] top;
    n = 0;
    d = b.dir;
    p = b.dir ^ 4'd1;
    if (b.cmd == CMD_FRAME) begin
      n_frames = sat_bump(n_frames);
      if (b.kind == KIND_U) begin
        if (b.uc >= UCODE_FIRST && b.uc <= UCODE_LAST) u_flags[b.uc - 3'd1] = 1'b1;
      end else if ((b.kind == KIND_I || b.kind == KIND_S) && d < NDIR) begin
        if (b.kind == KIND_I) begin
          prev = d_expect[d] - 15'd1;
          if (!d_seen[d]) begin
            d_seen[d]   = 1'b1;
            d_first[d]  = b.ns;
            d_expect[d] = b.ns + 15'd1;
          end else if (b.ns == prev) begin
            n_dups = sat_bump(n_dups);
          end else begin
            if (b.ns != d_expect[d]) begin
              ahead = b.ns - d_expect[d];
              if (!ahead[14]) n_gaps = sat_bump(n_gaps);
              else n_dups = sat_bump(n_dups);
            end
            d_expect[d] = b.ns + 15'd1;
          end
          d_last[d] = b.ns;
          if (d_iframes[d] != OBS_MAX) d_iframes[d] = d_iframes[d] + 14'd1;
        end
        if (p < NDIR) begin
          fwd = b.nr - d_ack[p];
          if (!d_ack_seen[p] || !fwd[14]) begin
            d_ack[p]      = b.nr;
            d_ack_seen[p] = 1'b1;
          end
        end
      end
      r = base_result(RES_ACK);
      r.last = 1'b1;
      want_q.push_back(r);
      n = 1;
    end else begin
      reports++;
      top = '0;
      for (int i = 0; i < NDIR; i++) begin
        if (d_seen[i]) begin
          base = d_ack_seen[i] ? d_ack[i] : d_first[i];
          raw  = d_last[i] + 15'd1 - base;
          if (raw[14]) est = '0;
          else est = (raw[13:0] < d_iframes[i]) ? raw[13:0] : d_iframes[i];
          if (est > top) top = est;
          r = base_result(RES_DIR);
          r.dir         = 4'(i);
          r.latest      = d_last[i];
          r.ack         = d_ack[i];
          r.ack_seen    = d_ack_seen[i];
          r.outstanding = est;
          want_q.push_back(r);
          n++;
        end
      end
      r = base_result(RES_SUMMARY);
      r.outstanding = top;
      r.last        = 1'b1;
      want_q.push_back(r);
      n++;
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  task automatic add_beat(input logic cmd, input logic [3:0] dir, input logic [1:0] kind,
                          input logic [2:0] uc, input logic [14:0] ns,
                          input logic [14:0] nr, input bit drain);
    frame_beat_t b;
    b = '{cmd: cmd, dir: dir, kind: kind, uc: uc, ns: ns, nr: nr, drain: drain};
    beat_q.push_back(b);
  endtask

  // driver
  always @(posedge clk) begin : drv
    int n;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_beat(cur, n);
        exp_cnt  <= exp_cnt + n;
        beats_in <= beats_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (beat_q.size() > 0 &&
            !(beat_q[0].drain && (in_valid || got_cnt != exp_cnt)) &&
            (quiet || $urandom_range(0, 99) >= 38)) begin
          cur = beat_q.pop_front();
          in_valid      <= 1'b1;
          in_command    <= cur.cmd;
          in_direction  <= cur.dir;
          in_frame_kind <= cur.kind;
          in_u_code     <= cur.uc;
          in_send_seq   <= cur.ns;
          in_recv_seq   <= cur.nr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    track_res_t w;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          $display("%0t unexpected result beat: expected none, actual kind %0d dir %0d",
                   $time, out_result_kind, out_dir_index);
          mismatches++;
        end else begin
          w = want_q.pop_front();
          check_field("result_kind", 32'(out_result_kind), 32'(w.kind));
          check_field("frame_count", out_frame_count, w.frames);
          check_field("gap_count", out_gap_count, w.gaps);
          check_field("duplicate_count", out_duplicate_count, w.dups);
          check_field("u_seen_flags", 32'(out_u_seen_flags), 32'(w.uflags));
          check_field("dir_index", 32'(out_dir_index), 32'(w.dir));
          check_field("latest_send", 32'(out_latest_send), 32'(w.latest));
          check_field("highest_ack", 32'(out_highest_ack), 32'(w.ack));
          check_field("ack_seen", 32'(out_ack_seen), 32'(w.ack_seen));
          check_field("outstanding", 32'(out_outstanding), 32'(w.outstanding));
          check_field("last", 32'(out_last), 32'(w.last));
          got_cnt <= got_cnt + 1;
        end
      end
      // long hold-off once, otherwise random stalls
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && beats_in >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 38);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stim
    logic [14:0] gen_ns [NDIR];
    logic [3:0]  d;
    logic [14:0] ns;
    int          sel;
    int          pick;
    for (int i = 0; i < NDIR; i++) begin
      d_seen[i] = 1'b0;     d_first[i] = '0;    d_expect[i] = '0;
      d_last[i] = '0;       d_ack[i] = '0;      d_ack_seen[i] = 1'b0;
      d_iframes[i] = '0;
      gen_ns[i] = 15'($urandom_range(0, 32767));
    end
    gen_ns[2] = 15'd32760;
    gen_ns[3] = 15'd32764;

    // directed beats
    add_beat(CMD_REPORT, 4'd0, KIND_U, UCODE_OTHER, 15'd0, 15'd0, 1'b0);
    for (int c = 0; c < 8; c++) add_beat(CMD_FRAME, 4'd7, KIND_U, 3'(c), 15'd32767, 15'd32767, 1'b0);
    add_beat(CMD_FRAME, 4'd0, KIND_UNUSED, UCODE_SPARE, 15'd32767, 15'd32767, 1'b0);
    add_beat(CMD_FRAME, 4'd0, KIND_I, UCODE_OTHER, 15'd32767, 15'd0, 1'b0);
    add_beat(CMD_FRAME, 4'd0, KIND_I, UCODE_OTHER, 15'd0, 15'd32767, 1'b0);
    add_beat(CMD_FRAME, 4'd0, KIND_I, UCODE_OTHER, 15'd0, 15'd0, 1'b0);
    add_beat(CMD_FRAME, 4'd0, KIND_I, UCODE_OTHER, 15'd5, 15'd0, 1'b0);
    add_beat(CMD_FRAME, 4'd0, KIND_I, UCODE_OTHER, 15'd2, 15'd0, 1'b0);
    add_beat(CMD_FRAME, 4'd1, KIND_S, UCODE_OTHER, 15'd32767, 15'd32767, 1'b0);
    add_beat(CMD_FRAME, 4'd1, KIND_S, UCODE_OTHER, 15'd0, 15'd3, 1'b0);
    add_beat(CMD_FRAME, 4'd1, KIND_S, UCODE_OTHER, 15'd0, 15'd1, 1'b0);
    add_beat(CMD_FRAME, 4'd1, KIND_I, UCODE_OTHER, 15'd16384, 15'd2, 1'b0);
    add_beat(CMD_FRAME, 4'd15, KIND_I, UCODE_OTHER, 15'd0, 15'd32767, 1'b0);
    add_beat(CMD_FRAME, 4'd14, KIND_I, UCODE_OTHER, 15'd32767, 15'd0, 1'b0);
    add_beat(CMD_REPORT, 4'd15, KIND_S, UCODE_SPARE, 15'd32767, 15'd32767, 1'b0);
    add_beat(CMD_FRAME, 4'd0, KIND_I, UCODE_OTHER, 15'd16385, 15'd0, 1'b0);
    add_beat(CMD_REPORT, 4'd0, KIND_U, UCODE_OTHER, 15'd0, 15'd0, 1'b1);

    // random sessions, mostly well-formed with some noise
    for (int k = 0; k < 300; k++) begin
      sel = $urandom_range(0, 99);
      d = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(0, 5)) : 4'($urandom_range(0, 15));
      if (sel < 8) begin
        add_beat(CMD_REPORT, d, 2'($urandom), 3'($urandom), 15'($urandom), 15'($urandom),
                 k == 150);
      end else if (sel < 58) begin
        ns = gen_ns[d];
        pick = $urandom_range(0, 99);
        if (pick < 8) ns = ns + 15'($urandom_range(1, 200));
        else if (pick < 14) ns = ns - 15'd1;
        else if (pick < 17) ns = ns - 15'($urandom_range(2, 50));
        gen_ns[d] = ns + 15'd1;
        add_beat(CMD_FRAME, d, KIND_I, 3'($urandom), ns,
                 gen_ns[d ^ 4'd1] - 15'($urandom_range(0, 4)), k == 150);
      end else if (sel < 72) begin
        add_beat(CMD_FRAME, d, KIND_S, 3'($urandom), 15'($urandom),
                 gen_ns[d ^ 4'd1] - 15'($urandom_range(0, 3)), k == 150);
      end else if (sel < 84) begin
        add_beat(CMD_FRAME, d, KIND_U, 3'($urandom_range(0, 7)), 15'($urandom),
                 15'($urandom), k == 150);
      end else begin
        add_beat(1'($urandom), 4'($urandom), 2'($urandom), 3'($urandom), 15'($urandom),
                 15'($urandom), k == 150);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (beat_q.size() != 0 || in_valid || got_cnt != exp_cnt);
    repeat (TAIL) @(negedge clk);

    if (want_q.size() != 0) begin
      $display("%0t results missing: expected %0d more, actual 0", $time, want_q.size());
      mismatches++;
    end
    $display("covered %0d beats with %0d table reports, %0d result beats checked",
             beats_in, reports, got_cnt);
    $display("gaps %0d, duplicates %0d, U flags %b, mismatches %0d",
             n_gaps, n_dups, u_flags, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
